// File: rtl/ipv4_address_extractor_assert.svh
// Assertion macros for the IPv4 address extractor checker.
// Clocked on aclk; disabled while aresetn is low.
`ifndef IPV4_ADDRESS_EXTRACTOR_ASSERT_SVH
`define IPV4_ADDRESS_EXTRACTOR_ASSERT_SVH

// Plain property checked every cycle out of reset.
`define IPV4AE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Antecedent implies consequent on the following cycle.
`define IPV4AE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ipv4ae_pkg.sv
// Shared types and character constants for the IPv4 address extractor.
// No dependencies.
`default_nettype none

package ipv4ae_pkg;

    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_DQUOTE   = 8'h22;
    localparam logic [7:0] CH_SQUOTE   = 8'h27;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;

    localparam logic [11:0] OCTET_MAX   = 12'd255;
    localparam logic [1:0]  DIGITS_MAX  = 2'd3;
    localparam logic [2:0]  OCTETS_MAX  = 3'd4;
    localparam logic [2:0]  OCTETS_HEAD = 3'd3;

    typedef struct packed {
        logic        active;
        logic        rejected;
        logic        port_skip;
        logic [2:0]  octet_count;
        logic [7:0]  octet_accum;
        logic [1:0]  digit_count;
        logic [23:0] partial_addr;
        logic        match_found;
        logic [31:0] match_addr;
    } tok_state_t;

endpackage

`default_nettype wire

// File: rtl/ipv4_address_extractor.sv
// IPv4 address extractor top level: input register, scanner, result register.
// Depends on ipv4ae_pkg and ipv4ae_scan.
//
// Usage:
//   s_axis carries one text byte per request (tdata), a byte-present flag
//   (tuser) and the end-of-cell mark (tlast). A request with tuser low and
//   tlast high ends a cell without a byte.
//   m_axis gives one result per cell: tuser = found, tdata = address with
//   the first octet in bits 31..24, zero when nothing was found.
//   Throughput: one request per cycle while s_axis_tready is high; each
//   byte is a single state update. A tlast request loads the input
//   register when it is taken; the scanner then feeds the result register,
//   which raises m_axis_tvalid, once that register is free or being taken.
//   A stalled m_axis holds the result; non-last bytes keep flowing behind
//   it, and s_axis_tready drops only when a second tlast request reaches the
//   scanner while the result register is still full.
//   Reset (aresetn low, synchronous) empties both registers and clears the
//   token and match state.
`default_nettype none

module ipv4_address_extractor import ipv4ae_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tuser,   // [0] char_valid
    input  wire logic        s_axis_tlast,   // end_of_cell
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] address
    output logic             m_axis_tuser    // [0] found
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_data_reg;
    logic        in_user_reg;
    logic        in_last_reg;
    tok_state_t  state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_found_reg;
    logic [31:0] out_addr_reg;

    logic        consume;
    logic        s_take;
    tok_state_t  scan_state;
    logic        scan_found;
    logic [31:0] scan_addr;

    ipv4ae_scan u_scan (
        .state_in    (state_reg),
        .char_code   (in_data_reg),
        .char_valid  (in_user_reg),
        .end_of_cell (in_last_reg),
        .state_out   (scan_state),
        .found       (scan_found),
        .address     (scan_addr)
    );

    // A last byte needs a free result slot.
    assign consume       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || consume;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        if (consume) begin
            state_next = scan_state;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (consume && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_data_reg <= s_axis_tdata;
            in_user_reg <= s_axis_tuser;
            in_last_reg <= s_axis_tlast;
        end
        if (consume && in_last_reg) begin
            out_found_reg <= scan_found;
            out_addr_reg  <= scan_addr;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_addr_reg;
    assign m_axis_tuser  = out_found_reg;

endmodule

`default_nettype wire

// File: rtl/ipv4ae_scan.sv
// Per-byte token scanner: next token state and cell result from one request.
// Depends on ipv4ae_pkg.
`default_nettype none

module ipv4ae_scan import ipv4ae_pkg::*; (
    input  tok_state_t  state_in,
    input  logic [7:0]  char_code,
    input  logic        char_valid,
    input  logic        end_of_cell,
    output tok_state_t  state_out,
    output logic        found,
    output logic [31:0] address
);

    function automatic logic is_sep(input logic [7:0] c);
        case (c) inside
            CH_SPACE, CH_TAB, CH_COMMA, CH_SEMI,
            CH_LPAREN, CH_RPAREN, CH_DQUOTE, CH_SQUOTE: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Token end acts as a closing dot.
    function automatic tok_state_t close_tok(input tok_state_t s);
        tok_state_t r;
        r = '0;
        r.match_found = s.match_found;
        r.match_addr  = s.match_addr;
        if (s.active && !s.rejected && !s.match_found &&
            s.digit_count != 2'd0 && s.octet_count == OCTETS_HEAD) begin
            r.match_found = 1'b1;
            r.match_addr  = {s.partial_addr, s.octet_accum};
        end
        return r;
    endfunction

    tok_state_t  st;
    tok_state_t  closed;
    logic [11:0] octet_value;
    logic        is_digit;

    assign is_digit    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign octet_value = {1'b0, state_in.octet_accum, 3'b000}
                       + {3'b000, state_in.octet_accum, 1'b0}
                       + {8'd0, char_code[3:0]};

    always_comb begin
        st = state_in;
        if (char_valid && !state_in.match_found) begin
            if (is_sep(char_code)) begin
                st = close_tok(state_in);
            end else begin
                if (!st.active) begin
                    st.active = 1'b1;
                    if (char_code == CH_LBRACKET) begin
                        st.rejected = 1'b1;
                    end
                end
                if (!st.rejected && !st.port_skip) begin
                    if (char_code == CH_COLON) begin
                        st.port_skip = 1'b1;
                    end else if (is_digit) begin
                        if (st.digit_count == DIGITS_MAX || octet_value > OCTET_MAX) begin
                            st.rejected = 1'b1;
                        end else begin
                            st.octet_accum = octet_value[7:0];
                            st.digit_count = st.digit_count + 2'd1;
                        end
                    end else if (char_code == CH_DOT) begin
                        if (st.digit_count == 2'd0 || st.octet_count >= OCTETS_MAX) begin
                            st.rejected = 1'b1;
                        end else begin
                            st.partial_addr = {st.partial_addr[15:0], st.octet_accum};
                            st.octet_count  = st.octet_count + 3'd1;
                            st.octet_accum  = 8'd0;
                            st.digit_count  = 2'd0;
                        end
                    end else begin
                        st.rejected = 1'b1;
                    end
                end
            end
        end
    end

    assign closed  = close_tok(st);
    assign found   = closed.match_found;
    assign address = closed.match_found ? closed.match_addr : 32'd0;

    always_comb begin
        if (end_of_cell) begin
            state_out = '0;
        end else begin
            state_out = st;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ipv4ae_checker.sv
// Port-level checker for the IPv4 address extractor, bound to the top level.
// Depends on ipv4_address_extractor_assert.svh.
`default_nettype none

`include "ipv4_address_extractor_assert.svh"

module ipv4ae_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    `IPV4AE_ASSERT_NEXT(a_result_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    `IPV4AE_ASSERT(a_no_match_zero, !(m_axis_tvalid && !m_axis_tuser) || (m_axis_tdata == 32'd0), "nonzero address without a match")

    `IPV4AE_ASSERT(a_result_from_last, !$rose(m_axis_tvalid) || $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2), "result without a last request")

    `IPV4AE_ASSERT(a_stall_cause, s_axis_tready || (m_axis_tvalid && !m_axis_tready), "input stalled while output free")

endmodule

bind ipv4_address_extractor ipv4ae_checker u_ipv4ae_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: tb/tb_ipv4_address_extractor.sv
`timescale 1ns / 100ps
// Self-checking testbench for ipv4_address_extractor: streams text cells byte by byte,
// predicts the found flag and address of each cell, and checks every result.
// Depends on ipv4ae_pkg and the ipv4_address_extractor RTL.

module tb_ipv4_address_extractor;
    import ipv4ae_pkg::*;

    localparam int ITEM_GOAL  = 1400;
    localparam int CALM_TAIL  = 150;
    localparam int HANG_LIMIT = 1000;
    localparam int N_ROWS     = 12;

    typedef struct packed {
        logic        found;
        logic [31:0] addr;
    } lookup_t;

    typedef struct packed {
        logic [7:0] code;
        logic       vld;
        logic       lst;
    } text_item_t;

    typedef struct packed {
        logic        active;
        logic        rejected;
        logic        port_skip;
        logic [2:0]  octets;
        logic [7:0]  accum;
        logic [1:0]  digits;
        logic [23:0] head;
        logic        hit;
        logic [31:0] hit_addr;
    } scan_state_t;

    typedef struct {
        string      text;
        logic [7:0] lead;
        bit         has_lead;
        bit         gap;        // no-byte request after the first byte
        bit         empty_end;  // cell closed by a request without a byte
        bit         typed;
        lookup_t    want;
    } cell_row_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] char_code
    logic        s_axis_tuser  = 1'b0;    // [0] char_valid
    logic        s_axis_tlast  = 1'b0;    // end_of_cell
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [31:0] m_axis_tdata;            // [31:0] address
    logic        m_axis_tuser;            // [0] found

    scan_state_t scan = '0;
    lookup_t     lookup_q[$];
    text_item_t  cell_q[$];
    cell_row_t   rows[N_ROWS];
    logic [7:0]  delim_set[8] = '{CH_SPACE, CH_TAB, CH_COMMA, CH_SEMI,
                                  CH_LPAREN, CH_RPAREN, CH_DQUOTE, CH_SQUOTE};

    int  err_cnt     = 0;
    int  byte_cnt    = 0;
    int  quiet_cycles = 0;
    bit  idle_enable = 1'b1;
    bit  idle_now    = 1'b0;
    bit  noise_on    = 1'b0;

    ipv4_address_extractor dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #6 aclk = ~aclk;

    // ---------------- address scanner prediction ----------------

    function automatic bit is_delim(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_COMMA || c == CH_SEMI ||
               c == CH_LPAREN || c == CH_RPAREN || c == CH_DQUOTE || c == CH_SQUOTE;
    endfunction

    // token end acts as a closing dot
    function automatic void end_token();
        if (scan.active && !scan.rejected && !scan.hit &&
            scan.digits != 2'd0 && scan.octets == OCTETS_HEAD) begin
            scan.hit      = 1'b1;
            scan.hit_addr = {scan.head, scan.accum};
        end
        scan.active    = 1'b0;
        scan.rejected  = 1'b0;
        scan.port_skip = 1'b0;
        scan.octets    = 3'd0;
        scan.accum     = 8'd0;
        scan.digits    = 2'd0;
        scan.head      = 24'd0;
    endfunction

    function automatic bit scan_item(input logic [7:0] c, input logic vld, input logic lst,
                                     output lookup_t res);
        logic [11:0] v;
        res = '0;
        if (vld && !scan.hit) begin
            if (is_delim(c)) begin
                end_token();
            end else begin
                if (!scan.active) begin
                    scan.active = 1'b1;
                    if (c == CH_LBRACKET)
                        scan.rejected = 1'b1;
                end
                if (!scan.rejected && !scan.port_skip) begin
                    if (c == CH_COLON) begin
                        scan.port_skip = 1'b1;
                    end else if (c >= CH_ZERO && c <= CH_NINE) begin
                        v = 12'(scan.accum) * 12'd10 + 12'(c - CH_ZERO);
                        if (scan.digits >= DIGITS_MAX || v > OCTET_MAX) begin
                            scan.rejected = 1'b1;
                        end else begin
                            scan.accum  = v[7:0];
                            scan.digits = scan.digits + 2'd1;
                        end
                    end else if (c == CH_DOT) begin
                        if (scan.digits == 2'd0 || scan.octets >= OCTETS_MAX) begin
                            scan.rejected = 1'b1;
                        end else begin
                            scan.head   = {scan.head[15:0], scan.accum};
                            scan.octets = scan.octets + 3'd1;
                            scan.accum  = 8'd0;
                            scan.digits = 2'd0;
                        end
                    end else begin
                        scan.rejected = 1'b1;
                    end
                end
            end
        end
        if (!lst)
            return 1'b0;
        end_token();
        res.found = scan.hit;
        res.addr  = scan.hit ? scan.hit_addr : 32'h0;
        scan = '0;
        return 1'b1;
    endfunction

    // ---------------- cell text generation ----------------

    function automatic void add_item(logic [7:0] code, logic vld, logic lst);
        text_item_t it;
        it = '{code: code, vld: vld, lst: lst};
        cell_q = {cell_q, it};
    endfunction

    function automatic void put_byte(logic [7:0] c);
        if (noise_on && $urandom_range(0, 24) == 0)
            add_item(8'($urandom), 1'b0, 1'b0);
        add_item(c, 1'b1, 1'b0);
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] c;
        c = 8'($urandom);
        return is_delim(c) ? 8'h78 : c;
    endfunction

    function automatic void put_num(int v, int zeros);
        repeat (zeros) put_byte(CH_ZERO);
        if (v >= 100)
            put_byte(8'(CH_ZERO + 8'(v / 100)));
        if (v >= 10)
            put_byte(8'(CH_ZERO + 8'((v / 10) % 10)));
        put_byte(8'(CH_ZERO + 8'(v % 10)));
    endfunction

    function automatic void put_good_octet();
        int v;
        int nd;
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = 255;
            2: v = $urandom_range(250, 255);
            default: v = $urandom_range(0, 255);
        endcase
        nd = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
        put_num(v, ($urandom_range(0, 7) == 0) ? 3 - nd : 0);
    endfunction

    function automatic void put_bad_octet();
        int v;
        case ($urandom_range(0, 2))
            0: put_num($urandom_range(256, 999), 0);
            1: begin
                v = $urandom_range(0, 999);
                put_num(v, (v >= 100) ? 1 : (v >= 10) ? 2 : 3);
            end
            default: ;  // empty octet
        endcase
    endfunction

    function automatic void put_dotted(int octets, int bad_at);
        for (int i = 0; i < octets; i++) begin
            if (i > 0)
                put_byte(CH_DOT);
            if (i == bad_at)
                put_bad_octet();
            else
                put_good_octet();
        end
    endfunction

    function automatic void put_token();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                put_dotted(4, -1);
                if ($urandom_range(0, 3) == 0) begin
                    put_byte(CH_COLON);
                    repeat ($urandom_range(0, 5)) put_byte(junk_byte());
                end
            end
            5: begin
                case ($urandom_range(0, 2))
                    0: put_dotted(5, -1);
                    1: put_dotted($urandom_range(1, 3), -1);
                    default: begin
                        put_dotted(4, -1);
                        put_byte(CH_DOT);
                    end
                endcase
            end
            6: put_dotted(4, $urandom_range(0, 3));
            7: begin
                put_byte($urandom_range(0, 1) ? CH_LBRACKET : CH_COLON);
                put_dotted(4, -1);
            end
            8: begin
                if ($urandom_range(0, 1))
                    put_byte(junk_byte());
                put_dotted(4, -1);
                put_byte(junk_byte());
            end
            default: repeat ($urandom_range(1, 6)) put_byte(junk_byte());
        endcase
    endfunction

    function automatic void put_delims();
        repeat ($urandom_range(1, 2)) put_byte(delim_set[$urandom_range(0, 7)]);
    endfunction

    function automatic void build_cell();
        int ntok;
        ntok = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        cell_q.delete();
        if ($urandom_range(0, 3) == 0)
            put_delims();
        for (int t = 0; t < ntok; t++) begin
            if (t > 0)
                put_delims();
            put_token();
        end
        if ($urandom_range(0, 4) == 0)
            put_delims();
        if (cell_q.size() == 0 || $urandom_range(0, 4) == 0)
            add_item(8'($urandom), 1'b0, 1'b1);
        else
            cell_q[$].lst = 1'b1;
    endfunction

    // ---------------- driving ----------------

    task automatic send_item(input logic [7:0] code, input logic vld, input logic lst,
                             input bit typed, input lookup_t want);
        lookup_t res;
        if (idle_now && $urandom_range(0, 9) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tuser  <= vld;
        s_axis_tlast  <= lst;
        do @(posedge aclk); while (!s_axis_tready);
        if (scan_item(code, vld, lst, res)) begin
            if (typed)
                res = want;
            lookup_q = {lookup_q, res};
        end
        if (vld)
            byte_cnt++;
    endtask

    task automatic send_cell(input bit typed, input lookup_t want);
        foreach (cell_q[i])
            send_item(cell_q[i].code, cell_q[i].vld, cell_q[i].lst, typed, want);
    endtask

    task automatic drain_lookups();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (lookup_q.size() != 0) @(posedge aclk);
    endtask

    // result side stalls
    initial begin : rx_stall
        int hold;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold != 0) begin
                hold--;
                if (hold == 0)
                    m_axis_tready <= 1'b1;
            end else if (idle_now && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                hold = $urandom_range(1, 11);
            end
        end
    end

    // ---------------- checking ----------------

    always @(posedge aclk) begin : result_check
        lookup_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (lookup_q.size() == 0) begin
                $error("unexpected result: found %0b address %h", m_axis_tuser, m_axis_tdata);
                err_cnt++;
            end else begin
                want = lookup_q.pop_front();
                if (m_axis_tuser !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, m_axis_tuser);
                    err_cnt++;
                end
                if (m_axis_tdata !== want.addr) begin
                    $error("address: expected %h, got %h", want.addr, m_axis_tdata);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        bit mid_paused;
        mid_paused = 1'b0;
        rows = '{
            '{"",                               8'h00, 0, 0, 1, 1, '{1'b0, 32'h0}},
            '{"0.0.0.0",                        8'h00, 0, 0, 0, 1, '{1'b1, 32'h0}},
            '{"255.255.255.255",                8'h00, 0, 0, 0, 1, '{1'b1, 32'hFFFFFFFF}},
            '{" 9.9.9.9",                       8'h00, 1, 0, 0, 1, '{1'b1, 32'h09090909}},
            '{"1.2.3.4",                        8'hFF, 1, 0, 0, 1, '{1'b0, 32'h0}},
            '{"[1.2.3.4",                       8'h00, 0, 0, 0, 1, '{1'b0, 32'h0}},
            '{":80 1.2.3.4.5 256.1.1.1",        8'h00, 0, 0, 0, 1, '{1'b0, 32'h0}},
            '{"1000.1.1.1 1..2.3 4.5.6.7.",     8'h00, 0, 0, 0, 1, '{1'b0, 32'h0}},
            '{"a\t(10.0.0.1:8080)\"x\" 7.7.7.7", 8'h00, 0, 0, 0, 0, '{1'b0, 32'h0}},
            '{"1.2.3,4.5.6.7;'8.9.10.11'",      8'h00, 0, 0, 0, 0, '{1'b0, 32'h0}},
            '{"12.34.56.78 ",                   8'h00, 0, 1, 1, 0, '{1'b0, 32'h0}},
            '{"199.249.3.201",                  8'h00, 0, 0, 0, 0, '{1'b0, 32'h0}}
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[r]) begin
            idle_now = $urandom_range(0, 1);
            cell_q.delete();
            if (rows[r].has_lead)
                put_byte(rows[r].lead);
            for (int i = 0; i < rows[r].text.len(); i++) begin
                put_byte(rows[r].text[i]);
                if (rows[r].gap && i == 0)
                    add_item(8'hA5, 1'b0, 1'b0);
            end
            if (rows[r].empty_end)
                add_item(8'h5A, 1'b0, 1'b1);
            else
                cell_q[$].lst = 1'b1;
            send_cell(rows[r].typed, rows[r].want);
        end
        drain_lookups();

        noise_on = 1'b1;
        while (byte_cnt < ITEM_GOAL) begin
            if (byte_cnt >= ITEM_GOAL - CALM_TAIL)
                idle_enable = 1'b0;
            idle_now = idle_enable && $urandom_range(0, 3) != 0;
            build_cell();
            send_cell(1'b0, '0);
            if (!mid_paused && byte_cnt >= ITEM_GOAL / 2) begin
                drain_lookups();
                mid_paused = 1'b1;
            end
        end

        drain_lookups();
        repeat (8) @(posedge aclk);
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: ipv4_address_extractor.f
+incdir+rtl
rtl/ipv4ae_pkg.sv
rtl/ipv4ae_scan.sv
rtl/ipv4_address_extractor.sv
rtl/ipv4ae_checker.sv
tb/tb_ipv4_address_extractor.sv
